// File: design/text_console_cursor_engine_macros.svh
// Assertion macros for the text console cursor engine checker.
// No dependencies; included by the checker file.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TCCE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCCE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/tcce_pkg.sv
// Shared types and constants for the text console cursor engine.
// No dependencies; used by the top level and its checker.
package tcce_pkg;

   localparam int SCREEN_COLS = 80;
   localparam int SCREEN_ROWS = 25;
   localparam int TAB_STOP    = 4;

   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int CHAR_W = 8;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'd0;
   localparam logic [CHAR_W-1:0] COLOR_RESET  = 8'd7;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_BACK  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_SET   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_SCROLL = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_REPORT = 2'd3
   } kind_type;

endpackage

// File: design/text_console_cursor_engine.sv
// Sequence per command: accept, command step, report; a tab takes one command
// step per space written, and a wrap off the bottom line adds a scroll step.
// Throughput: one command at a time, paced by the sequencer feeding a single
// registered result slot; each result cycle waits while that slot is stalled.
// Reset: cursor at the origin, text color 7, no result pending, ready for a command.
module text_console_cursor_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_operation,
   input  logic [tcce_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcce_pkg::COL_W-1:0]     req_new_col,
   input  logic [tcce_pkg::ROW_W-1:0]     req_new_row,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_kind,
   output logic [tcce_pkg::COL_W-1:0]     rsp_col,
   output logic [tcce_pkg::ROW_W-1:0]     rsp_row,
   output logic [tcce_pkg::CHAR_W-1:0]    rsp_cell_char,
   output logic [tcce_pkg::CHAR_W-1:0]    rsp_cell_color,
   output logic                           rsp_last,
   input  logic                           csr_wr_en,
   input  logic [tcce_pkg::CHAR_W-1:0]    csr_wr_data
);
   import tcce_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_CMD    = 4'b0010,
      S_SCROLL = 4'b0100,
      S_REPORT = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [CHAR_W-1:0]   color_ff;
   op_type              op_ff;
   logic [CHAR_W-1:0]   char_ff;
   logic [COL_W-1:0]    new_col_ff;
   logic [ROW_W-1:0]    new_row_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            kind_ff, kind_in;
   logic [COL_W-1:0]    rcol_ff, rcol_in;
   logic [ROW_W-1:0]    rrow_ff, rrow_in;
   logic [CHAR_W-1:0]   rchar_ff, rchar_in;
   logic [CHAR_W-1:0]   rcolor_ff, rcolor_in;
   logic                rlast_ff, rlast_in;

   logic                out_free, emit, req_xfer;
   logic [COL_W:0]      col_inc;
   logic [COL_W-1:0]    col_next;
   logic                wrap, at_bottom, is_tab;
   logic [ROW_W-1:0]    row_inc;
   logic [CHAR_W-1:0]   put_char;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign col_inc   = {1'b0, col_ff} + 1'b1;
   assign col_next  = col_inc[COL_W-1:0];
   assign wrap      = col_inc >= (COL_W+1)'(SCREEN_COLS);
   assign at_bottom = row_ff == ROW_W'(SCREEN_ROWS - 1);
   assign row_inc   = row_ff + 1'b1;
   assign is_tab    = (char_ff == CHAR_TAB);
   assign put_char  = is_tab ? CHAR_SPACE : char_ff;

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      emit      = 1'b0;
      kind_in   = KIND_WRITE;
      rcol_in   = '0;
      rrow_in   = '0;
      rchar_in  = '0;
      rcolor_in = '0;
      rlast_in  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CMD;
            end
         end
         S_CMD: begin
            if (out_free) begin
               state_in = S_REPORT;
               unique case (op_ff)
                  OP_PUT: begin
                     priority if (char_ff == CHAR_NEWLINE) begin
                        col_in = '0;
                        if (at_bottom) begin
                           emit    = 1'b1;
                           kind_in = KIND_SCROLL;
                        end else begin
                           row_in = row_inc;
                        end
                     end else if (char_ff == CHAR_RETURN) begin
                        col_in = '0;
                     end else begin
                        emit      = 1'b1;
                        kind_in   = KIND_WRITE;
                        rcol_in   = col_ff;
                        rrow_in   = row_ff;
                        rchar_in  = put_char;
                        rcolor_in = color_ff;
                        if (wrap) begin
                           col_in = '0;
                           if (at_bottom) begin
                              state_in = S_SCROLL;
                           end else begin
                              row_in = row_inc;
                           end
                        end else begin
                           col_in = col_next;
                           if (is_tab && ((col_next % TAB_STOP) != 0)) begin
                              state_in = S_CMD;
                           end
                        end
                     end
                  end
                  OP_BACK: begin
                     if (col_ff != '0) begin
                        col_in    = col_ff - 1'b1;
                        emit      = 1'b1;
                        rcol_in   = col_ff - 1'b1;
                        rrow_in   = row_ff;
                        rcolor_in = color_ff;
                        rchar_in  = CHAR_BLANK;
                     end else if (row_ff != '0) begin
                        row_in    = row_ff - 1'b1;
                        col_in    = COL_W'(SCREEN_COLS - 1);
                        emit      = 1'b1;
                        rcol_in   = COL_W'(SCREEN_COLS - 1);
                        rrow_in   = row_ff - 1'b1;
                        rcolor_in = color_ff;
                        rchar_in  = CHAR_BLANK;
                     end
                  end
                  OP_CLEAR: begin
                     emit    = 1'b1;
                     kind_in = KIND_CLEAR;
                     col_in  = '0;
                     row_in  = '0;
                  end
                  OP_SET: begin
                     col_in = (new_col_ff > COL_W'(SCREEN_COLS - 1)) ?
                              COL_W'(SCREEN_COLS - 1) : new_col_ff;
                     row_in = (new_row_ff > ROW_W'(SCREEN_ROWS - 1)) ?
                              ROW_W'(SCREEN_ROWS - 1) : new_row_ff;
                  end
               endcase
            end
         end
         S_SCROLL: begin
            if (out_free) begin
               emit     = 1'b1;
               kind_in  = KIND_SCROLL;
               state_in = S_REPORT;
            end
         end
         S_REPORT: begin
            if (out_free) begin
               emit     = 1'b1;
               kind_in  = KIND_REPORT;
               rcol_in  = col_ff;
               rrow_in  = row_ff;
               rlast_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         color_ff     <= COLOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            color_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff      <= op_type'(req_operation);
         char_ff    <= req_char_code;
         new_col_ff <= req_new_col;
         new_row_ff <= req_new_row;
      end
      if (emit) begin
         kind_ff   <= kind_in;
         rcol_ff   <= rcol_in;
         rrow_ff   <= rrow_in;
         rchar_ff  <= rchar_in;
         rcolor_ff <= rcolor_in;
         rlast_ff  <= rlast_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_col        = rcol_ff;
   assign rsp_row        = rrow_ff;
   assign rsp_cell_char  = rchar_ff;
   assign rsp_cell_color = rcolor_ff;
   assign rsp_last       = rlast_ff;

endmodule

// File: design/tcce_checker.sv
// Port-level checker for the text console cursor engine, with its bind.
// Depends on tcce_pkg and text_console_cursor_engine_macros.svh.
`include "text_console_cursor_engine_macros.svh"

module tcce_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [1:0]                     rsp_kind,
   input logic [tcce_pkg::COL_W-1:0]     rsp_col,
   input logic [tcce_pkg::ROW_W-1:0]     rsp_row,
   input logic                           rsp_last
);
   import tcce_pkg::*;

   logic is_report;
   logic on_screen;

   assign is_report = (rsp_kind == KIND_REPORT);
   assign on_screen = (rsp_col < COL_W'(SCREEN_COLS)) && (rsp_row < ROW_W'(SCREEN_ROWS));

   `TCCE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
   `TCCE_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready, "no busy cycle")
   `TCCE_ASSERT_NOW(a_idle_report, clock, reset, req_ready && rsp_valid, rsp_last, "stale result")
   `TCCE_ASSERT_NOW(a_last, clock, reset, rsp_valid, rsp_last == is_report, "bad last")
   `TCCE_ASSERT_NOW(a_in_screen, clock, reset, rsp_valid, on_screen, "result off screen")

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (.*);
